// File: sv/rgbcrc_pkg.sv
// shared types and constants for the rgb565 colour range counter
// no dependencies

package rgbcrc_pkg;

   localparam int COUNT_W      = 11;
   localparam int CHAN_W       = 6;
   localparam int NUM_OBJECTS  = 4;
   localparam int NUM_CHANNELS = 3;
   localparam int NUM_COUNTS   = NUM_OBJECTS * NUM_CHANNELS;

   localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
   localparam logic [COUNT_W-1:0] MIN_COUNT_RESET = COUNT_W'(100);

   typedef logic [CHAN_W-1:0]  chan_type;
   typedef logic [COUNT_W-1:0] count_type;

   // entry object*3+channel, channels red, green, blue, objects pink, rocket, mushroom, yellow
   localparam chan_type RANGE_LO [NUM_COUNTS] = '{
      6'd26, 6'd13, 6'd17,
      6'd11, 6'd16, 6'd15,
      6'd11, 6'd18, 6'd6,
      6'd11, 6'd16, 6'd0
   };
   localparam chan_type RANGE_HI [NUM_COUNTS] = '{
      6'd31, 6'd19, 6'd24,
      6'd17, 6'd29, 6'd20,
      6'd16, 6'd25, 6'd24,
      6'd17, 6'd36, 6'd4
   };

   typedef struct packed {
      logic advance;
      logic last;
   } step_type;

endpackage

// File: sv/rgbcrc_classify.sv
// rgb565 unpacking and per-object channel range compares
// depends on rgbcrc_pkg

module rgbcrc_classify import rgbcrc_pkg::*; (
   input  logic [7:0]            high_byte,
   input  logic [7:0]            low_byte,
   output logic [NUM_COUNTS-1:0] hit
);

   chan_type chan [NUM_CHANNELS];

   assign chan[0] = {1'b0, high_byte[7:3]};
   assign chan[1] = {high_byte[2:0], low_byte[7:5]};
   assign chan[2] = {1'b0, low_byte[4:0]};

   for (genvar k = 0; k < NUM_COUNTS; k++) begin : g_cmp
      assign hit[k] = (chan[k % NUM_CHANNELS] >= RANGE_LO[k]) &&
                      (chan[k % NUM_CHANNELS] <= RANGE_HI[k]);
   end

endmodule

// File: sv/rgbcrc_counter_bank.sv
// twelve saturating channel counters and the per-object threshold test
// depends on rgbcrc_pkg

module rgbcrc_counter_bank import rgbcrc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  step_type               step,
   input  logic [NUM_COUNTS-1:0]  hit,
   input  count_type              min_count,
   output logic [NUM_OBJECTS-1:0] found
);

   logic [NUM_COUNTS-1:0][COUNT_W-1:0] count_ff;
   logic [NUM_COUNTS-1:0][COUNT_W-1:0] count_in;
   logic [NUM_COUNTS-1:0][COUNT_W-1:0] count_upd;
   logic [NUM_COUNTS-1:0]              above;

   for (genvar k = 0; k < NUM_COUNTS; k++) begin : g_cnt
      assign count_upd[k] = (hit[k] && count_ff[k] != COUNT_MAX) ?
                            count_ff[k] + COUNT_W'(1) : count_ff[k];
      assign above[k]     = count_upd[k] > min_count;
   end

   for (genvar o = 0; o < NUM_OBJECTS; o++) begin : g_obj
      assign found[o] = &above[o*NUM_CHANNELS +: NUM_CHANNELS];
   end

   always_comb begin
      count_in = count_ff;
      if (step.advance) begin
         if (step.last) begin
            count_in = '0;
         end else begin
            count_in = count_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_clear_after_line: assert property (@(posedge clock) disable iff (reset)
      step.advance && step.last |=> count_ff == '0)
      else $error("counters not cleared after last pixel");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !step.advance |=> $stable(count_ff))
      else $error("counters moved without a pixel");

   a_no_flag_at_max: assert property (@(posedge clock) disable iff (reset)
      min_count == COUNT_MAX |-> found == '0)
      else $error("flag set with unreachable minimum");

endmodule

// File: sv/rgb565_colour_range_counter.sv
// rgb565 colour range counter: pixel input register, counter bank, result register
// depends on rgbcrc_pkg, rgbcrc_classify and rgbcrc_counter_bank
// a last pixel goes from the pixel input register to the result register on rsp_
// throughput: one pixel per cycle, one update stage; rsp_stall holds a last pixel
// reset: synchronous, clears the counters and sets min_count to 100

module rgb565_colour_range_counter import rgbcrc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_high_byte,
   input  logic [7:0]   req_low_byte,
   input  logic         req_last_pixel,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_pink_object_found,
   output logic         rsp_rocket_object_found,
   output logic         rsp_mushroom_object_found,
   output logic         rsp_yellow_object_found,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [COUNT_W-1:0] csr_min_count
);

   logic                   pix_valid_ff;
   logic                   pix_valid_in;
   logic [7:0]             high_byte_ff;
   logic [7:0]             low_byte_ff;
   logic                   last_ff;
   count_type              min_count_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [NUM_OBJECTS-1:0] flags_ff;
   logic [NUM_COUNTS-1:0]  hit;
   logic [NUM_OBJECTS-1:0] found;
   logic                   out_free;
   logic                   accept;
   step_type               step;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign step.advance = pix_valid_ff && (!last_ff || out_free);
   assign step.last    = last_ff;
   assign req_stall    = pix_valid_ff && !step.advance;
   assign accept       = req_valid && !req_stall;
   assign pix_valid_in = accept || (pix_valid_ff && !step.advance);
   assign rsp_valid_in = (step.advance && step.last) || (rsp_valid_ff && rsp_stall);
   assign csr_ready    = 1'b1;

   rgbcrc_classify u_classify (
      .high_byte (high_byte_ff),
      .low_byte  (low_byte_ff),
      .hit       (hit)
   );

   rgbcrc_counter_bank u_counter_bank (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .hit       (hit),
      .min_count (min_count_ff),
      .found     (found)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_count_ff <= MIN_COUNT_RESET;
      end else begin
         pix_valid_ff <= pix_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            min_count_ff <= csr_min_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         high_byte_ff <= req_high_byte;
         low_byte_ff  <= req_low_byte;
         last_ff      <= req_last_pixel;
      end
      if (step.advance && step.last) begin
         flags_ff <= found;
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_pink_object_found     = flags_ff[0];
   assign rsp_rocket_object_found   = flags_ff[1];
   assign rsp_mushroom_object_found = flags_ff[2];
   assign rsp_yellow_object_found   = flags_ff[3];

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> pix_valid_ff && last_ff)
      else $error("input stalled without a waiting last pixel");

   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step.advance && step.last))
      else $error("result raised without a last pixel");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> !$past(step.advance && step.last))
      else $error("stalled result overwritten");

endmodule
